>>> rtl/core/alfl_pkg.sv
// ----------------------------------------------------------------------------
// alfl_pkg
// Shared types and constants for the slot-pool linked list with a free list.
// ----------------------------------------------------------------------------
`default_nettype none

package alfl_pkg;

  // Pool size and derived widths. A pointer is one bit wider than an index so
  // that the value SLOTS can stand for the null link.
  localparam int SLOTS  = 64;
  localparam int IW     = $clog2(SLOTS);
  localparam int PW     = $clog2(SLOTS + 1);
  localparam logic [PW-1:0] NIL = PW'(SLOTS);

  // Fixed field widths of the command and result words.
  localparam int ACT_W  = 2;
  localparam int ID_W   = 16;
  localparam int PRI_W  = 8;
  localparam int DIST_W = 32;
  localparam int WAIT_W = 16;
  localparam int SLOT_W = 6;

  // Command codes.
  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_WALK,
    S_REM,
    S_OUT
  } state_t;

  // One stored record.
  typedef struct packed {
    logic [ID_W-1:0]   item_id;
    logic [PRI_W-1:0]  item_priority;
    logic [DIST_W-1:0] item_distance;
    logic [WAIT_W-1:0] item_wait;
  } rec_t;

  // Access request from the sequencer to the slot pool.
  typedef struct packed {
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          lk_we;
    logic [IW-1:0] lk_addr;
    logic [PW-1:0] lk_data;
    logic          rec_we;
    logic [IW-1:0] rec_addr;
    logic          clear;
  } pool_req_t;

  // A link at or beyond the pool size is treated as null.
  function automatic logic is_null(input logic [PW-1:0] ptr);
    return ptr >= NIL;
  endfunction

  // Slot index carried by a non-null pointer.
  function automatic logic [IW-1:0] to_idx(input logic [PW-1:0] ptr);
    return ptr[IW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/alfl_cmd_if.sv
// ----------------------------------------------------------------------------
// alfl_cmd_if
// Command channel: one word carries an action and the record fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface alfl_cmd_if
  import alfl_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [ID_W-1:0]   item_id;
  logic [PRI_W-1:0]  item_priority;
  logic [DIST_W-1:0] item_distance;
  logic [WAIT_W-1:0] item_wait;

  modport source (
    output valid, action, item_id, item_priority, item_distance, item_wait,
    input  ready
  );

  modport sink (
    input  valid, action, item_id, item_priority, item_distance, item_wait,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/alfl_res_if.sv
// ----------------------------------------------------------------------------
// alfl_res_if
// Result channel: one word carries a status flag and a slot number.
// ----------------------------------------------------------------------------
`default_nettype none

interface alfl_res_if
  import alfl_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [SLOT_W-1:0] slot;

  modport source (
    output valid, ok, slot,
    input  ready
  );

  modport sink (
    input  valid, ok, slot,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/alfl_pool.sv
// ----------------------------------------------------------------------------
// alfl_pool
// Slot storage: the next-link memory with per-entry valid bits, the record
// id memory used by the walks, and the rest of each record.
// ----------------------------------------------------------------------------
`default_nettype none

module alfl_pool
  import alfl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire pool_req_t req,
  input  wire rec_t      rec,
  output logic [PW-1:0]  link,
  output logic [ID_W-1:0] id
);

  logic [PW-1:0]   link_mem [SLOTS];
  logic [ID_W-1:0] id_mem   [SLOTS];
  logic [PRI_W+DIST_W+WAIT_W-1:0] data_mem [SLOTS];

  logic [SLOTS-1:0] valid;
  logic [PW-1:0]    link_raw;
  logic             vld_q;
  logic [IW-1:0]    addr_q;

  // A link entry not written since reset or clear reads as its chain value.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.clear) begin
      valid <= '0;
    end else if (req.lk_we) begin
      valid[req.lk_addr] <= 1'b1;
    end
  end

  // Registered read of the link and id at one address.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      link_raw <= link_mem[req.rd_addr];
      id       <= id_mem[req.rd_addr];
      vld_q    <= valid[req.rd_addr];
      addr_q   <= req.rd_addr;
    end
  end

  // Link write port.
  always_ff @(posedge clk) begin
    if (req.lk_we) begin
      link_mem[req.lk_addr] <= req.lk_data;
    end
  end

  // Record write port.
  always_ff @(posedge clk) begin
    if (req.rec_we) begin
      id_mem[req.rec_addr]   <= rec.item_id;
      data_mem[req.rec_addr] <= {rec.item_priority, rec.item_distance, rec.item_wait};
    end
  end

  // The chain value of slot i is i+1, which is null for the last slot.
  assign link = vld_q ? link_raw : (PW'(addr_q) + PW'(1));

endmodule

`default_nettype wire

>>> rtl/core/array_linked_list_free_list.sv
// ----------------------------------------------------------------------------
// array_linked_list_free_list
// Fixed pool of slots holding a linked list of records and a free list,
// both threaded through one next-link memory. Supports insert, search by id,
// remove by id and clear.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake     Word
//   cmd      in   valid/ready   action, item_id, item_priority,
//                               item_distance, item_wait
//   res      out  valid/ready   ok, slot
//
// One word is handled at a time. Insert reads the link of the free-list head
// and then fills the slot; clear goes straight to the result; search and
// remove walk the list, and a successful remove then bypasses the found slot.
// The walk reads one link per cycle from the link memory. Reset clears the link
// valid bits at once; no clearing pass is needed. cmd.ready is low from
// acceptance until the result word has been taken on res.
// ----------------------------------------------------------------------------
`default_nettype none

module array_linked_list_free_list
  import alfl_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  alfl_cmd_if.sink   cmd,
  alfl_res_if.source res
);

  state_t state, state_next;

  action_t           act, act_next;
  logic [ID_W-1:0]   key, key_next;
  rec_t              rec, rec_next;
  logic [PW-1:0]     head, head_next;
  logic [PW-1:0]     free, free_next;
  logic [PW-1:0]     cur, cur_next;
  logic [PW-1:0]     prev, prev_next;
  logic [PW-1:0]     flink, flink_next;
  logic [IW-1:0]     steps, steps_next;
  logic              ok, ok_next;
  logic [SLOT_W-1:0] slot, slot_next;

  pool_req_t         req;
  logic [PW-1:0]     pool_link;
  logic [ID_W-1:0]   pool_id;

  logic    acc;
  action_t act_in;
  logic    match;
  logic    walk_end;

  alfl_pool u_pool (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rec  (rec),
    .link (pool_link),
    .id   (pool_id)
  );

  assign acc      = cmd.valid && cmd.ready;
  assign act_in   = action_t'(cmd.action);
  assign match    = (pool_id == key);
  assign walk_end = is_null(pool_link) || (steps == IW'(SLOTS - 1));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (act_in)
            ACT_INSERT: state_next = is_null(free) ? S_OUT : S_INS;
            ACT_CLEAR:  state_next = S_OUT;
            default:    state_next = is_null(head) ? S_OUT : S_WALK;
          endcase
        end
      end
      S_INS: state_next = S_OUT;
      S_WALK: begin
        if (match) begin
          state_next = (act == ACT_REMOVE) ? S_REM : S_OUT;
        end else if (walk_end) begin
          state_next = S_OUT;
        end
      end
      S_REM: state_next = S_OUT;
      S_OUT: begin
        if (res.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Pool requests and datapath updates for each state.
  always_comb begin
    act_next   = act;
    key_next   = key;
    rec_next   = rec;
    head_next  = head;
    free_next  = free;
    cur_next   = cur;
    prev_next  = prev;
    flink_next = flink;
    steps_next = steps;
    ok_next    = ok;
    slot_next  = slot;
    req        = '0;
    case (state)
      S_IDLE: begin
        if (acc) begin
          act_next   = act_in;
          key_next   = cmd.item_id;
          rec_next   = '{item_id:       cmd.item_id,
                         item_priority: cmd.item_priority,
                         item_distance: cmd.item_distance,
                         item_wait:     cmd.item_wait};
          steps_next = '0;
          prev_next  = NIL;
          cur_next   = head;
          ok_next    = 1'b0;
          slot_next  = '0;
          case (act_in)
            ACT_INSERT: begin
              // Fetch the link of the free-list head.
              req.rd_en   = !is_null(free);
              req.rd_addr = to_idx(free);
            end
            ACT_CLEAR: begin
              req.clear = 1'b1;
              head_next = NIL;
              free_next = '0;
              ok_next   = 1'b1;
            end
            default: begin
              // Start the walk at the list head.
              req.rd_en   = !is_null(head);
              req.rd_addr = to_idx(head);
            end
          endcase
        end
      end
      S_INS: begin
        // Pop the free slot, fill it and push it on the list head.
        req.lk_we    = 1'b1;
        req.lk_addr  = to_idx(free);
        req.lk_data  = head;
        req.rec_we   = 1'b1;
        req.rec_addr = to_idx(free);
        free_next    = pool_link;
        head_next    = free;
        ok_next      = 1'b1;
        slot_next    = SLOT_W'(free);
      end
      S_WALK: begin
        if (match) begin
          ok_next   = 1'b1;
          slot_next = SLOT_W'(cur);
          if (act == ACT_REMOVE) begin
            // Push the found slot on the free list and keep its old link.
            req.lk_we   = 1'b1;
            req.lk_addr = to_idx(cur);
            req.lk_data = free;
            free_next   = cur;
            flink_next  = pool_link;
          end
        end else if (!walk_end) begin
          req.rd_en   = 1'b1;
          req.rd_addr = to_idx(pool_link);
          prev_next   = cur;
          cur_next    = pool_link;
          steps_next  = steps + IW'(1);
        end
      end
      S_REM: begin
        // Bypass the removed slot.
        if (is_null(prev)) begin
          head_next = flink;
        end else begin
          req.lk_we   = 1'b1;
          req.lk_addr = to_idx(prev);
          req.lk_data = flink;
        end
      end
      default: begin
      end
    endcase
  end

  // Handshake outputs.
  always_comb begin
    cmd.ready = (state == S_IDLE);
    res.valid = (state == S_OUT);
    res.ok    = ok;
    res.slot  = slot;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= NIL;
      free  <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      free  <= free_next;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    act   <= act_next;
    key   <= key_next;
    rec   <= rec_next;
    cur   <= cur_next;
    prev  <= prev_next;
    flink <= flink_next;
    steps <= steps_next;
    ok    <= ok_next;
    slot  <= slot_next;
  end

endmodule

`default_nettype wire

>>> tb/array_linked_list_free_list_test.sv
// ----------------------------------------------------------------------------
// array_linked_list_free_list_test
// Self-checking testbench for the slot-pool linked list with a free list.
// A queue of command words drives the cmd channel with random gaps. A
// predictor keeps its own copy of the list and the free chain and computes
// the expected ok and slot for every accepted word. A monitor takes result
// words with random stalls and compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module array_linked_list_free_list_test;
  import alfl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 450;
  localparam int HANG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 80;

  // One command word and the answer it should produce.
  typedef struct {
    action_t             act;
    logic [ID_W-1:0]     id;
    logic [PRI_W-1:0]    pri;
    logic [DIST_W-1:0]   distance;
    logic [WAIT_W-1:0]   mins;
  } command_t;

  typedef struct {
    logic              ok;
    logic [SLOT_W-1:0] slot;
  } answer_t;

  logic clk;
  logic rst;

  alfl_cmd_if cmd_ch ();
  alfl_res_if res_ch ();

  array_linked_list_free_list dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  // Shadow of the slot pool: only the links and ids matter for the answers.
  logic [PW-1:0]   pool_link [SLOTS];
  logic [ID_W-1:0] pool_key  [SLOTS];
  logic [PW-1:0]   list_head;
  logic [PW-1:0]   free_head;

  command_t pending_cmds [$];
  answer_t  due_answers  [$];

  int failures;
  int hang_cycles;

  command_t sent;
  answer_t  want;
  int       send_idle;
  bit       send_calm;
  int       take_idle;
  bit       take_calm;

  // Links every slot into the free chain and empties the list.
  function automatic void rebuild_chain();
    list_head = NIL;
    free_head = '0;
    for (int i = 0; i < SLOTS; i++) begin
      pool_link[i] = PW'(i + 1);
    end
  endfunction

  // Applies one command to the shadow pool and returns its answer.
  function automatic answer_t apply_command(command_t c);
    answer_t       a;
    logic [PW-1:0] cur;
    logic [PW-1:0] prv;
    logic [PW-1:0] s;
    bit            hit;
    a.ok   = 1'b0;
    a.slot = '0;
    case (c.act)
      ACT_INSERT: begin
        if (free_head < NIL) begin
          s = free_head;
          free_head = pool_link[s[IW-1:0]];
          pool_key[s[IW-1:0]] = c.id;
          pool_link[s[IW-1:0]] = list_head;
          list_head = s;
          a.ok = 1'b1;
          a.slot = s[SLOT_W-1:0];
        end
      end
      ACT_SEARCH, ACT_REMOVE: begin
        cur = list_head;
        prv = NIL;
        hit = 1'b0;
        // The walk is bounded to the pool size; any link at or past it ends it.
        for (int steps = 0; steps < SLOTS && !hit && cur < NIL; steps++) begin
          if (pool_key[cur[IW-1:0]] == c.id) begin
            hit = 1'b1;
          end else begin
            prv = cur;
            cur = pool_link[cur[IW-1:0]];
          end
        end
        if (hit) begin
          a.ok = 1'b1;
          a.slot = cur[SLOT_W-1:0];
          if (c.act == ACT_REMOVE) begin
            if (prv < NIL) begin
              pool_link[prv[IW-1:0]] = pool_link[cur[IW-1:0]];
            end else begin
              list_head = pool_link[cur[IW-1:0]];
            end
            pool_link[cur[IW-1:0]] = free_head;
            free_head = cur;
          end
        end
      end
      default: begin
        rebuild_chain();
        a.ok = 1'b1;
      end
    endcase
    return a;
  endfunction

  // Queues a command word; fields that the action ignores are random.
  task automatic queue_cmd(action_t act, logic [ID_W-1:0] id);
    command_t c;
    c.act      = act;
    c.id       = id;
    c.pri      = PRI_W'($urandom);
    c.distance = $urandom;
    c.mins     = WAIT_W'($urandom);
    pending_cmds.push_back(c);
  endtask

  task automatic queue_insert(logic [ID_W-1:0] id, logic [PRI_W-1:0] pri,
                              logic [DIST_W-1:0] distance, logic [WAIT_W-1:0] mins);
    command_t c;
    c.act      = ACT_INSERT;
    c.id       = id;
    c.pri      = pri;
    c.distance = distance;
    c.mins     = mins;
    pending_cmds.push_back(c);
  endtask

  // Mostly a narrow set of ids so that searches and removes hit, and
  // duplicates pile up; the rest sit at the top of the id range or spread over it.
  function automatic logic [ID_W-1:0] draw_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      return ID_W'($urandom_range(0, 15));
    end else if (r == 7) begin
      return ID_W'(16'hFFFF - $urandom_range(0, 3));
    end
    return ID_W'($urandom);
  endfunction

  // Clock and reset.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.action = ACT_INSERT;
    cmd_ch.item_id = '0;
    cmd_ch.item_priority = '0;
    cmd_ch.item_distance = '0;
    cmd_ch.item_wait = '0;
    res_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // Command driver: presents the front of the queue after a random gap and
  // feeds every accepted word to the predictor.
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      send_idle = $urandom_range(0, 16);
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        sent = pending_cmds.pop_front();
        due_answers.push_back(apply_command(sent));
        if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
        send_idle = send_calm ? 0 : $urandom_range(0, 16);
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (send_idle == 0 && pending_cmds.size() > 0) begin
          cmd_ch.valid <= 1'b1;
          cmd_ch.action <= pending_cmds[0].act;
          cmd_ch.item_id <= pending_cmds[0].id;
          cmd_ch.item_priority <= pending_cmds[0].pri;
          cmd_ch.item_distance <= pending_cmds[0].distance;
          cmd_ch.item_wait <= pending_cmds[0].mins;
        end else begin
          cmd_ch.valid <= 1'b0;
          if (send_idle > 0) send_idle--;
        end
      end
    end
  end

  // Result monitor: stalls each result word a random number of cycles and
  // checks it against the oldest expected answer.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      take_idle = $urandom_range(0, 16);
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (due_answers.size() == 0) begin
          $display("%0t: result word with none expected: ok %0d slot %0d",
                   $realtime, res_ch.ok, res_ch.slot);
          failures++;
        end else begin
          want = due_answers.pop_front();
          if (res_ch.ok !== want.ok) begin
            $display("%0t: ok mismatch: expected %0d, actual %0d",
                     $realtime, want.ok, res_ch.ok);
            failures++;
          end
          if (res_ch.slot !== want.slot) begin
            $display("%0t: slot mismatch: expected %0d, actual %0d",
                     $realtime, want.slot, res_ch.slot);
            failures++;
          end
        end
        if ($urandom_range(0, 29) == 0) take_calm = !take_calm;
        take_idle = take_calm ? 0 : $urandom_range(0, 16);
      end
      if (take_idle == 0) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b0;
        if (res_ch.valid) take_idle--;
      end
    end
  end

  // Watchdog: ends the run when neither channel moves a word for too long.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      hang_cycles <= 0;
    end else if (hang_cycles >= HANG_LIMIT) begin
      $display("array_linked_list_free_list verification failed");
      $finish;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

  // Stimulus and end of run.
  initial begin
    int target;
    int n;
    int r;
    failures = 0;
    hang_cycles = 0;
    send_calm = 1'b0;
    take_calm = 1'b1;
    rebuild_chain();
    for (int i = 0; i < SLOTS; i++) pool_key[i] = '0;

    // Directed part: empty list, field extremes, duplicates, removal at the
    // head, middle and tail, free-slot reuse, and clear.
    queue_cmd(ACT_SEARCH, 16'h0005);
    queue_cmd(ACT_REMOVE, 16'h0005);
    queue_insert(16'h0000, 8'h00, 32'h0000_0000, 16'h0000);
    queue_insert(16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
    queue_insert(16'h1234, 8'h5A, 32'hA5A5_5A5A, 16'h00FF);
    queue_insert(16'h1234, 8'hA5, 32'h5A5A_A5A5, 16'hFF00);
    queue_cmd(ACT_SEARCH, 16'h1234);
    queue_cmd(ACT_SEARCH, 16'h0000);
    queue_cmd(ACT_SEARCH, 16'hFFFF);
    queue_cmd(ACT_SEARCH, 16'h7777);
    queue_cmd(ACT_REMOVE, 16'h1234);
    queue_cmd(ACT_SEARCH, 16'h1234);
    queue_cmd(ACT_REMOVE, 16'hFFFF);
    queue_cmd(ACT_REMOVE, 16'h0000);
    queue_cmd(ACT_INSERT, 16'hAAAA);
    queue_cmd(ACT_REMOVE, 16'h1234);
    queue_cmd(ACT_REMOVE, 16'h1234);
    queue_cmd(ACT_CLEAR, 16'h0000);
    queue_cmd(ACT_SEARCH, 16'hAAAA);
    queue_cmd(ACT_INSERT, 16'h5555);
    queue_cmd(ACT_CLEAR, 16'hFFFF);
    queue_cmd(ACT_CLEAR, 16'h0000);

    // Random part: fill episodes insert up to or past a full pool and then
    // search and remove; churn episodes mix all actions on a partly used pool.
    target = pending_cmds.size() + RANDOM_WORDS;
    while (pending_cmds.size() < target) begin
      if ($urandom_range(0, 2) == 0) begin
        queue_cmd(ACT_CLEAR, draw_key());
        n = $urandom_range(SLOTS, SLOTS + 4);
        repeat (n) queue_cmd(ACT_INSERT, draw_key());
        n = $urandom_range(10, 30);
        repeat (n) begin
          queue_cmd($urandom_range(0, 1) ? ACT_SEARCH : ACT_REMOVE, draw_key());
        end
      end else begin
        n = $urandom_range(30, 60);
        repeat (n) begin
          r = $urandom_range(0, 99);
          if (r < 40) queue_cmd(ACT_INSERT, draw_key());
          else if (r < 70) queue_cmd(ACT_SEARCH, draw_key());
          else if (r < 96) queue_cmd(ACT_REMOVE, draw_key());
          else queue_cmd(ACT_CLEAR, draw_key());
        end
      end
    end

    // Wait for every word to be sent and answered, then let the block settle.
    @(negedge rst);
    do begin
      @(posedge clk);
    end while (pending_cmds.size() > 0 || cmd_ch.valid || due_answers.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0 && due_answers.size() == 0) begin
      $display("array_linked_list_free_list verification clean");
    end else begin
      $display("array_linked_list_free_list verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/alfl_pkg.sv
rtl/core/alfl_cmd_if.sv
rtl/core/alfl_res_if.sv
rtl/core/alfl_pool.sv
rtl/core/array_linked_list_free_list.sv
tb/array_linked_list_free_list_test.sv
